### rtl/core/esv_pkg.sv
// ----------------------------------------------------------------------------
// esv_pkg
// Shared types and constants of the ElGamal sign and verify unit.
// ----------------------------------------------------------------------------
package esv_pkg;

	localparam int W    = 32;
	localparam int CW   = $clog2(W);
	localparam int IDXW = 2;

	localparam logic [IDXW-1:0] REG_MODULUS     = 2'd0;
	localparam logic [IDXW-1:0] REG_GENERATOR   = 2'd1;
	localparam logic [IDXW-1:0] REG_PRIVATE_KEY = 2'd2;
	localparam logic [IDXW-1:0] REG_PUBLIC_KEY  = 2'd3;

	localparam logic CMD_SIGN   = 1'b0;
	localparam logic CMD_VERIFY = 1'b1;

	typedef struct packed {
		logic         command;
		logic [W-1:0] message;
		logic [W-1:0] nonce;
		logic [W-1:0] sig_r;
		logic [W-1:0] sig_s;
	} req_t;

	typedef struct packed {
		logic [W-1:0] result_r;
		logic [W-1:0] result_s;
		logic         valid_res;
		logic         nonce_bad;
	} rsp_t;

	typedef struct packed {
		logic [W-1:0] modulus;
		logic [W-1:0] generator;
		logic [W-1:0] private_key;
		logic [W-1:0] public_key;
	} cfg_t;

endpackage

### rtl/core/esv_mulmod.sv
// ----------------------------------------------------------------------------
// esv_mulmod
// Shift-and-add modular multiplier, one modular add per cycle, msb first.
// ----------------------------------------------------------------------------
module esv_mulmod (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [esv_pkg::W-1:0] a,
	input  logic [esv_pkg::W-1:0] b,
	input  logic [esv_pkg::W-1:0] m,
	output logic                done,
	output logic [esv_pkg::W-1:0] res
);
	import esv_pkg::*;

	logic          busy_q, ph_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  res_q, a_q, b_q, m_q;
	logic [W-1:0]  addend, room, sum;
	logic          last;

	assign addend = ph_q ? (b_q[W-1] ? a_q : '0) : res_q;
	assign room   = m_q - addend;
	assign sum    = (res_q >= room) ? (res_q - room) : (res_q + addend);
	assign last   = ph_q && (cnt_q == CW'(W-1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				ph_q   <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				ph_q <= ~ph_q;
				if (ph_q) cnt_q <= cnt_q + 1'b1;
				if (last) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			res_q <= '0;
			a_q   <= a;
			b_q   <= b;
			m_q   <= m;
		end else if (busy_q) begin
			res_q <= sum;
			if (ph_q) b_q <= {b_q[W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign res  = res_q;

	a_res_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (res_q < m_q)) else $error("mulmod result not reduced");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("mulmod restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> done_q) else $error("mulmod finished without done");
endmodule

### rtl/core/esv_divider.sv
// ----------------------------------------------------------------------------
// esv_divider
// Restoring divider, one quotient bit per cycle, for the euclid steps.
// ----------------------------------------------------------------------------
module esv_divider (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [esv_pkg::W-1:0] dividend,
	input  logic [esv_pkg::W-1:0] divisor,
	output logic                  done,
	output logic [esv_pkg::W-1:0] quo,
	output logic [esv_pkg::W-1:0] rem
);
	import esv_pkg::*;

	logic          busy_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quo_q, rem_q, d_q;
	logic [W:0]    sh, diff;
	logic          ge;

	assign sh   = {rem_q, quo_q[W-1]};
	assign ge   = sh >= {1'b0, d_q};
	assign diff = sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(W-1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W-1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			d_q   <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : sh[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

### rtl/core/esv_seq.sv
// ----------------------------------------------------------------------------
// esv_seq
// Sequencer: euclid inverse, exponentiations and reductions on the shared units.
// ----------------------------------------------------------------------------
module esv_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  esv_pkg::req_t req,
	input  esv_pkg::cfg_t cfg,
	input  logic          out_free,
	output logic          idle,
	output logic          fin,
	output esv_pkg::rsp_t rsp
);
	import esv_pkg::*;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_KRED    = 5'd1;
	localparam logic [4:0] S_EUC_CHK = 5'd2;
	localparam logic [4:0] S_EUC_DIV = 5'd3;
	localparam logic [4:0] S_EUC_MUL = 5'd4;
	localparam logic [4:0] S_GRED    = 5'd5;
	localparam logic [4:0] S_POW_ACC = 5'd6;
	localparam logic [4:0] S_POW_SQ  = 5'd7;
	localparam logic [4:0] S_XRED    = 5'd8;
	localparam logic [4:0] S_XR      = 5'd9;
	localparam logic [4:0] S_MRED    = 5'd10;
	localparam logic [4:0] S_SMUL    = 5'd11;
	localparam logic [4:0] S_YRED    = 5'd12;
	localparam logic [4:0] S_V2      = 5'd13;
	localparam logic [4:0] S_LEFT    = 5'd14;
	localparam logic [4:0] S_CMP     = 5'd15;
	localparam logic [4:0] S_DONE    = 5'd16;

	logic [4:0]    state_q, pret_q;
	logic          op_q;
	req_t          req_q;
	logic [W-1:0]  p_q, n;
	logic [W-1:0]  r0_q, r1_q, t0_q, t1_q, q_q, rn_q, w_q, a1_q, left_q;
	logic [W-1:0]  pbase_q, pacc_q, pexp_q;
	logic [CW-1:0] pcnt_q;
	rsp_t          rsp_q;

	logic          mul_start, mul_done, div_start, div_done;
	logic [W-1:0]  mul_a, mul_b, mul_m, mul_res, div_quo, div_rem;
	logic          is_mul, is_div;
	logic [W-1:0]  tn, dn;

	assign n = p_q - 1'b1;

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_m  = p_q;
		is_mul = 1'b1;
		unique case (state_q)
			S_KRED:    begin mul_a = W'(1); mul_b = req_q.nonce;   mul_m = n; end
			S_EUC_MUL: begin mul_a = t1_q;  mul_b = q_q;           mul_m = n; end
			S_GRED:    begin mul_a = W'(1); mul_b = cfg.generator; end
			S_POW_ACC: begin mul_a = pacc_q; mul_b = pbase_q; is_mul = pexp_q[0]; end
			S_POW_SQ:  begin mul_a = pbase_q; mul_b = pbase_q; end
			S_XRED:    begin mul_a = W'(1); mul_b = cfg.private_key; mul_m = n; end
			S_XR:      begin mul_a = w_q;   mul_b = pacc_q;        mul_m = n; end
			S_MRED:    begin mul_a = W'(1); mul_b = req_q.message; mul_m = n; end
			S_SMUL:    begin mul_a = t0_q;  mul_b = w_q;           mul_m = n; end
			S_YRED:    begin mul_a = W'(1); mul_b = cfg.public_key; end
			S_LEFT:    begin mul_a = a1_q;  mul_b = pacc_q; end
			default:   is_mul = 1'b0;
		endcase
	end

	assign is_div    = (state_q == S_EUC_DIV);
	assign mul_start = is_mul && !op_q;
	assign div_start = is_div && !op_q;
	assign tn = (t0_q >= mul_res) ? (t0_q - mul_res) : (t0_q + (n - mul_res));
	assign dn = (mul_res >= w_q) ? (mul_res - w_q) : (mul_res + (n - w_q));

	esv_mulmod u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a), .b(mul_b), .m(mul_m), .done(mul_done), .res(mul_res)
	);

	esv_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(r0_q), .divisor(r1_q), .done(div_done), .quo(div_quo), .rem(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pret_q  <= S_IDLE;
			op_q    <= 1'b0;
			pcnt_q  <= '0;
		end else begin
			if (mul_start || div_start) op_q <= 1'b1;
			if (mul_done || div_done) op_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) begin
					if (req.command == CMD_SIGN)
						state_q <= (cfg.modulus < W'(3)) ? S_DONE : S_KRED;
					else if (cfg.modulus >= W'(3) && req.sig_r != '0 && req.sig_r < cfg.modulus
						&& req.sig_s != '0 && req.sig_s < cfg.modulus)
						state_q <= S_YRED;
					else
						state_q <= S_DONE;
				end
				S_KRED:    if (mul_done) state_q <= S_EUC_CHK;
				S_EUC_CHK: state_q <= (r1_q == '0) ? ((r0_q == W'(1)) ? S_GRED : S_DONE)
					: S_EUC_DIV;
				S_EUC_DIV: if (div_done) state_q <= S_EUC_MUL;
				S_EUC_MUL: if (mul_done) state_q <= S_EUC_CHK;
				S_GRED: if (mul_done) begin
					pcnt_q  <= '0;
					pret_q  <= (req_q.command == CMD_SIGN) ? S_XRED : S_CMP;
					state_q <= S_POW_ACC;
				end
				S_POW_ACC: if (!pexp_q[0] || mul_done) state_q <= S_POW_SQ;
				S_POW_SQ: if (mul_done) begin
					pcnt_q  <= pcnt_q + 1'b1;
					state_q <= (pcnt_q == CW'(W-1)) ? pret_q : S_POW_ACC;
				end
				S_XRED: if (mul_done) state_q <= S_XR;
				S_XR:   if (mul_done) state_q <= S_MRED;
				S_MRED: if (mul_done) state_q <= S_SMUL;
				S_SMUL: if (mul_done) state_q <= S_DONE;
				S_YRED: if (mul_done) begin
					pcnt_q  <= '0;
					pret_q  <= S_V2;
					state_q <= S_POW_ACC;
				end
				S_V2: begin
					pcnt_q  <= '0;
					pret_q  <= S_LEFT;
					state_q <= S_POW_ACC;
				end
				S_LEFT: if (mul_done) state_q <= S_GRED;
				S_CMP:  state_q <= S_DONE;
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (start) begin
				req_q <= req;
				p_q   <= cfg.modulus;
				rsp_q.result_r  <= '0;
				rsp_q.result_s  <= '0;
				rsp_q.valid_res <= 1'b0;
				rsp_q.nonce_bad <= (req.command == CMD_SIGN) && (cfg.modulus < W'(3));
			end
			S_KRED: if (mul_done) begin
				r0_q <= n;
				r1_q <= mul_res;
				t0_q <= '0;
				t1_q <= W'(1);
			end
			S_EUC_CHK: if (r1_q == '0 && r0_q != W'(1)) rsp_q.nonce_bad <= 1'b1;
			S_EUC_DIV: if (div_done) begin
				q_q  <= div_quo;
				rn_q <= div_rem;
			end
			S_EUC_MUL: if (mul_done) begin
				r0_q <= r1_q;
				r1_q <= rn_q;
				t0_q <= t1_q;
				t1_q <= tn;
			end
			S_GRED: if (mul_done) begin
				pbase_q <= mul_res;
				pacc_q  <= W'(1);
				pexp_q  <= (req_q.command == CMD_SIGN) ? req_q.nonce : req_q.message;
			end
			S_POW_ACC: if (mul_done) pacc_q <= mul_res;
			S_POW_SQ: if (mul_done) begin
				pbase_q <= mul_res;
				pexp_q  <= pexp_q >> 1;
			end
			S_XRED: if (mul_done) w_q <= mul_res;
			S_XR:   if (mul_done) w_q <= mul_res;
			S_MRED: if (mul_done) w_q <= dn;
			S_SMUL: if (mul_done) begin
				rsp_q.result_r <= pacc_q;
				rsp_q.result_s <= mul_res;
			end
			S_YRED: if (mul_done) begin
				pbase_q <= mul_res;
				pacc_q  <= W'(1);
				pexp_q  <= req_q.sig_r;
			end
			S_V2: begin
				a1_q    <= pacc_q;
				pbase_q <= req_q.sig_r;
				pacc_q  <= W'(1);
				pexp_q  <= req_q.sig_s;
			end
			S_LEFT: if (mul_done) left_q <= mul_res;
			S_CMP:  rsp_q.valid_res <= (pacc_q == left_q);
			default: ;
		endcase
	end

	assign idle = (state_q == S_IDLE);
	assign fin  = (state_q == S_DONE) && out_free;
	assign rsp  = rsp_q;

	a_coef_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EUC_CHK) |-> (t1_q < n)) else $error("euclid coefficient not reduced");
	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POW_SQ) |-> (pacc_q < p_q)) else $error("power accumulator not reduced");
	a_fin_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> (state_q == S_IDLE)) else $error("sequencer did not return to idle");
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_start && div_start)) else $error("two units started together");
endmodule

### rtl/core/elgamal_sign_verify_top.sv
// ----------------------------------------------------------------------------
// elgamal_sign_verify_top
// ElGamal signature unit: signs with g^k and k^-1 (m - x r), verifies y^r r^s.
//
// channel  direction  handshake              payload
// req      in         req_valid / req_ready  command, message, nonce, sig_r, sig_s
// rsp      out        rsp_valid / rsp_ready  result_r, result_s, valid_res, nonce_bad
// cfg      in         cfg_we                 cfg_index, cfg_data
//
// one transaction at a time; products run on the shared multiplier, divides on the divider
// an exponentiation is 32 squarings plus up to 32 products
// sign: euclid inverse of the nonce, one exponentiation and further products; verify: three exponentiations
// req_ready is high only while the sequencer is idle; a result held in the
// output register stalls the sequencer until rsp_ready takes it
// reset sets the modulus to 3 and the other keys to zero
// ----------------------------------------------------------------------------
module elgamal_sign_verify_top (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  esv_pkg::req_t            req,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output esv_pkg::rsp_t            rsp,
	input  logic                     cfg_we,
	input  logic [esv_pkg::IDXW-1:0] cfg_index,
	input  logic [esv_pkg::W-1:0]    cfg_data
);
	import esv_pkg::*;

	cfg_t cfg_q;
	rsp_t rsp_q, seq_rsp;
	logic rsp_valid_q, idle, fin, out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.modulus     <= W'(3);
			cfg_q.generator   <= '0;
			cfg_q.private_key <= '0;
			cfg_q.public_key  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODULUS:     cfg_q.modulus     <= cfg_data;
				REG_GENERATOR:   cfg_q.generator   <= cfg_data;
				REG_PRIVATE_KEY: cfg_q.private_key <= cfg_data;
				REG_PUBLIC_KEY:  cfg_q.public_key  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = idle;

	esv_seq u_seq (
		.clk(clk), .arst_n(arst_n), .start(req_valid && req_ready), .req(req),
		.cfg(cfg_q), .out_free(out_free), .idle(idle), .fin(fin), .rsp(seq_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid_q <= 1'b0;
		else if (out_free) rsp_valid_q <= fin;
	end

	always_ff @(posedge clk) begin
		if (fin) rsp_q <= seq_rsp;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
endmodule

### sim/tb_elgamal_sign_verify_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_elgamal_sign_verify_top
// Self-checking bench for the ElGamal sign and verify unit: computes signatures
// and verdicts in SystemVerilog, compares each response field by field, and runs
// under several modulus and key settings with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_elgamal_sign_verify_top;
	import esv_pkg::*;

	localparam int WATCHDOG_CYCLES = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [IDXW-1:0] cfg_index = '0;
	logic [W-1:0] cfg_data = '0;

	logic [63:0] p_reg, g_reg, x_reg, y_reg;
	rsp_t expected_rsp_q[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit recv_hold = 1'b0;
	int idle_cycles = 0;

	elgamal_sign_verify_top uut (.*);

	always #5 clk = ~clk;

	function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		logic [127:0] prod;
		prod = (a % m) * (b % m);
		return 64'(prod % m);
	endfunction

	function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
		logic [63:0] acc;
		acc = 1 % m;
		b = b % m;
		while (e != 0) begin
			if (e[0]) acc = mulmod(acc, b, m);
			b = mulmod(b, b, m);
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic bit invmod(logic [63:0] a, logic [63:0] n, output logic [63:0] inv);
		logic [63:0] r0, r1, t0, t1, q, rn, tn, qt;
		r0 = n; r1 = a % n; t0 = 0; t1 = 1; inv = 0;
		while (r1 != 0) begin
			q = r0 / r1;
			rn = r0 - q * r1;
			qt = mulmod(q % n, t1, n);
			tn = (t0 >= qt) ? t0 - qt : t0 + (n - qt);
			r0 = r1; r1 = rn; t0 = t1; t1 = tn;
		end
		inv = t0;
		return r0 == 1;
	endfunction

	function automatic rsp_t predict_signature(req_t it);
		rsp_t o;
		logic [63:0] n, kinv, r, xr, d, mm, ssr, sss;
		o = '0;
		if (it.command == CMD_SIGN) begin
			if (p_reg < 3) o.nonce_bad = 1'b1;
			else begin
				n = p_reg - 1;
				if (!invmod(64'(it.nonce), n, kinv)) o.nonce_bad = 1'b1;
				else begin
					r = powmod(g_reg, 64'(it.nonce), p_reg);
					xr = mulmod(x_reg, r, n);
					mm = 64'(it.message) % n;
					d = (mm >= xr) ? mm - xr : mm + (n - xr);
					o.result_r = r[W-1:0];
					o.result_s = W'(mulmod(kinv, d, n));
				end
			end
		end else begin
			ssr = 64'(it.sig_r); sss = 64'(it.sig_s);
			if (p_reg >= 3 && ssr >= 1 && ssr <= p_reg - 1 && sss >= 1 && sss <= p_reg - 1)
				o.valid_res = mulmod(powmod(y_reg, ssr, p_reg), powmod(ssr, sss, p_reg),
					p_reg) == powmod(g_reg, 64'(it.message), p_reg);
		end
		return o;
	endfunction

	task automatic write_reg(logic [IDXW-1:0] idx, logic [W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MODULUS:     p_reg = 64'(val);
			REG_GENERATOR:   g_reg = 64'(val);
			REG_PRIVATE_KEY: x_reg = 64'(val);
			default:         y_reg = 64'(val);
		endcase
	endtask

	task automatic wait_drained();
		while (expected_rsp_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_keys(logic [W-1:0] p, logic [W-1:0] g, logic [W-1:0] x);
		wait_drained();
		write_reg(REG_MODULUS, p);
		write_reg(REG_GENERATOR, g);
		write_reg(REG_PRIVATE_KEY, x);
		write_reg(REG_PUBLIC_KEY, W'(powmod(64'(g), 64'(x), 64'(p))));
	endtask

	task automatic send_item(req_t it);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
		req <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		expected_rsp_q.push_back(predict_signature(it));
		req_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic req_t make_sign(logic [W-1:0] m, logic [W-1:0] k);
		req_t it;
		it = '0; it.command = CMD_SIGN; it.message = m; it.nonce = k;
		it.sig_r = $urandom; it.sig_s = $urandom;
		return it;
	endfunction

	function automatic req_t make_verify(logic [W-1:0] m, logic [W-1:0] r, logic [W-1:0] s);
		req_t it;
		it = '0; it.command = CMD_VERIFY; it.message = m; it.sig_r = r; it.sig_s = s;
		it.nonce = $urandom;
		return it;
	endfunction

	// sign then, if the nonce is accepted, verify the produced pair, sometimes with a corrupted field
	task automatic sign_and_check(logic [W-1:0] m, logic [W-1:0] k, bit corrupt);
		rsp_t sg;
		req_t it;
		it = make_sign(m, k);
		sg = predict_signature(it);
		send_item(it);
		if (!sg.nonce_bad) begin
			if (corrupt) begin
				case ($urandom_range(2))
					0: m = m ^ (32'h1 << $urandom_range(31));
					1: sg.result_r = sg.result_r ^ (32'h1 << $urandom_range(31));
					default: sg.result_s = sg.result_s ^ (32'h1 << $urandom_range(31));
				endcase
			end
			send_item(make_verify(m, sg.result_r, sg.result_s));
		end
	endtask

	task automatic test_reset_defaults();
		send_item(make_sign(32'd5, 32'd1));
		send_item(make_verify(32'd0, 32'd1, 32'd1));
		wait_drained();
	endtask

	task automatic test_directed();
		set_keys(32'd2, 32'd1, 32'd1);
		send_item(make_sign(32'd7, 32'd1));
		send_item(make_verify(32'd0, 32'd1, 32'd1));
		set_keys(32'd467, 32'd2, 32'd127);
		sign_and_check(32'd100, 32'd213, 1'b0);
		send_item(make_sign(32'd100, 32'd0));
		send_item(make_sign(32'd100, 32'd466));
		send_item(make_sign(32'd100, 32'd2));
		send_item(make_sign(32'hFFFF_FFFF, 32'hFFFF_FFFF));
		sign_and_check(32'd0, 32'd467, 1'b0);
		send_item(make_verify(32'd5, 32'd0, 32'd3));
		send_item(make_verify(32'd5, 32'd3, 32'd0));
		send_item(make_verify(32'd5, 32'd467, 32'd3));
		send_item(make_verify(32'd5, 32'd3, 32'd467));
		send_item(make_verify(32'd5, 32'd466, 32'd466));
		send_item(make_verify(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		set_keys(32'hFFFF_FFFB, 32'h0000_0005, 32'hFFFF_FFFF);
		sign_and_check(32'hFFFF_FFFF, 32'hFFFF_FFFD, 1'b0);
		sign_and_check(32'h1234_5678, 32'd1, 1'b1);
		send_item(make_sign(32'd9, 32'd0));
		// generator above the modulus
		set_keys(32'd11, 32'd13, 32'd3);
		sign_and_check(32'd4, 32'd3, 1'b0);
		wait_drained();
	endtask

	task automatic run_random(int count, int idle_pct, int stall_pct);
		int sent;
		logic [W-1:0] p;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(3))
				0: p = 32'd1019;
				1: p = 32'd65521;
				2: p = 32'hFFFF_FFFB;
				default: p = $urandom_range(2, 3) == 2 ? 32'd7 : 32'd2147483647;
			endcase
			set_keys(p, $urandom, $urandom);
			repeat (6) begin
				case ($urandom_range(9))
					0, 1: send_item(make_verify($urandom, $urandom, $urandom));
					2: send_item(make_sign($urandom, $urandom));
					default: sign_and_check($urandom, $urandom_range(1, p - 2),
						$urandom_range(1) == 1);
				endcase
				sent += 2;
			end
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		recv_hold = 1'b1;
		fork
			begin
				repeat (3) send_item(make_sign($urandom, $urandom));
			end
			begin
				repeat (20000) @(posedge clk);
				recv_hold = 1'b0;
			end
		join
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (!arst_n) rsp_ready <= 1'b0;
		else rsp_ready <= !recv_hold && !(recv_stall_pct != 0 &&
			$urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			if (expected_rsp_q.size() == 0) begin
				$display("%0t unexpected response %p", $time, rsp);
				errors++;
			end else begin
				automatic rsp_t e = expected_rsp_q.pop_front();
				if (rsp.result_r !== e.result_r) begin
					$display("%0t result_r exp %h got %h", $time, e.result_r, rsp.result_r);
					errors++;
				end
				if (rsp.result_s !== e.result_s) begin
					$display("%0t result_s exp %h got %h", $time, e.result_s, rsp.result_s);
					errors++;
				end
				if (rsp.valid_res !== e.valid_res) begin
					$display("%0t valid_res exp %b got %b", $time, e.valid_res, rsp.valid_res);
					errors++;
				end
				if (rsp.nonce_bad !== e.nonce_bad) begin
					$display("%0t nonce_bad exp %b got %b", $time, e.nonce_bad, rsp.nonce_bad);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || !arst_n || cfg_we)
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		p_reg = 3; g_reg = 0; x_reg = 0; y_reg = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_defaults();
		test_directed();
		run_random(40, 0, 0);
		run_random(30, 68, 0);
		run_random(30, 0, 68);
		run_random(30, 9, 9);
		test_backpressure();
		wait_drained();
		if (errors == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule
